// File: hdl/teq_pkg.sv
// Package for the timer expiry queue: command, entry and result types and codes.
// Used by every module of the block but teq_ram; depends on nothing.
package teq_pkg;

  localparam int TimeW = 48;
  localparam int TagW  = 32;
  localparam int SlotW = 4;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_CANCEL  = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SM_ADD,
    SM_PICK,
    SM_NEXT
  } scan_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_CREAD,
    ST_CDEC,
    ST_OTHER,
    ST_EREAD,
    ST_EOUT
  } state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [TimeW-1:0] expire_time;
    logic [TimeW-1:0] repeat_interval;
    logic [SlotW-1:0] target_slot;
    logic [TagW-1:0]  target_tag;
    logic [TimeW-1:0] current_time;
  } cmd_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] interval;
    logic [TimeW-1:0] expire;
  } entry_t;

  typedef struct packed {
    kind_t            kind;
    logic [SlotW-1:0] slot;
    logic [TagW-1:0]  tag;
    logic             ok;
    logic             earliest_changed;
  } rec_t;

  typedef struct packed {
    kind_t            kind;
    logic [SlotW-1:0] slot;
    logic [TagW-1:0]  tag;
    logic             ok;
    logic             earliest_changed;
    logic             next_valid;
    logic [TimeW-1:0] next_expire;
    logic             last;
  } res_t;

endpackage

// File: hdl/teq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module teq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/teq_ctrl.sv
// Sequencer of the timer queue: table scans, read-modify-write of entries,
// result recording and emission. Depends on teq_pkg; drives the two RAMs.
module teq_ctrl import teq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  cmd_t                        cmd,
  output logic                        ent_we,
  output logic [$clog2(CAPACITY)-1:0] ent_waddr,
  output entry_t                      ent_wdata,
  output logic [$clog2(CAPACITY)-1:0] ent_raddr,
  input  entry_t                      ent_rdata,
  output logic                        rec_we,
  output logic [$clog2(CAPACITY)-1:0] rec_waddr,
  output rec_t                        rec_wdata,
  output logic [$clog2(CAPACITY)-1:0] rec_raddr,
  input  rec_t                        rec_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output res_t                        res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

  state_t             state_r, state_nxt;
  scan_mode_t         mode_r, mode_nxt;
  cmd_t               cmd_r;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CAPACITY-1:0] due_r, due_nxt;
  logic [TagW-1:0]    tag_cnt_r, tag_cnt_nxt;
  logic [AW-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic               rd_vld_r;
  logic [AW-1:0]      rd_idx_r;
  logic               any_r, any_nxt;
  logic [TimeW-1:0]   best_r, best_nxt;
  logic [AW-1:0]      best_idx_r, best_idx_nxt;
  logic [TimeW-1:0]   best_ival_r, best_ival_nxt;
  logic [TagW-1:0]    best_tag_r, best_tag_nxt;
  logic               free_r, free_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic               first_r, first_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      emit_r, emit_nxt;
  logic               nv_r, nv_nxt;
  logic [TimeW-1:0]   nx_r, nx_nxt;

  logic               accept;
  logic               start_scan;
  logic               last_res;
  logic [TimeW:0]     resched_sum;
  logic [TimeW-1:0]   resched;
  logic [AW-1:0]      cslot;
  logic               cslot_ok;

  assign accept     = cmd_valid && cmd_ready;
  assign start_scan = (state_nxt == ST_SCAN) && (state_r != ST_SCAN);
  assign last_res   = (emit_r == n_r - CW'(1));

  // saturating reschedule time of the picked entry
  assign resched_sum = {1'b0, cmd_r.current_time} + {1'b0, best_ival_r};
  assign resched     = resched_sum[TimeW] ? {TimeW{1'b1}} : resched_sum[TimeW-1:0];

  assign cslot    = AW'(cmd_r.target_slot);
  assign cslot_ok = (32'(cmd_r.target_slot) < CAPACITY);

  // next state
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (op_t'(cmd.op))
            OP_ADD: begin
              state_nxt = ST_SCAN;
              mode_nxt  = SM_ADD;
            end
            OP_CANCEL: state_nxt = ST_CREAD;
            OP_EXPIRE: begin
              state_nxt = ST_SCAN;
              mode_nxt  = SM_PICK;
            end
            default:   state_nxt = ST_OTHER;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == LastIdx) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (mode_r == SM_NEXT) begin
          state_nxt = ST_EREAD;
        end else if (mode_r == SM_PICK && any_r) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_SCAN;
          mode_nxt  = SM_NEXT;
        end
      end
      ST_CREAD: state_nxt = ST_CDEC;
      ST_CDEC, ST_OTHER: begin
        state_nxt = ST_SCAN;
        mode_nxt  = SM_NEXT;
      end
      ST_EREAD: state_nxt = ST_EOUT;
      ST_EOUT: begin
        if (res_ready) state_nxt = last_res ? ST_IDLE : ST_EREAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and memory addressing
  always_comb begin
    cmd_ready = (state_r == ST_IDLE);
    res_valid = (state_r == ST_EOUT);
    ent_raddr = (state_r == ST_CREAD) ? cslot : scan_cnt_r;
    rec_raddr = emit_r[AW-1:0];
    res.kind             = rec_rdata.kind;
    res.slot             = rec_rdata.slot;
    res.tag              = rec_rdata.tag;
    res.ok               = rec_rdata.ok;
    res.earliest_changed = rec_rdata.earliest_changed;
    res.next_valid       = nv_r;
    res.next_expire      = nx_r;
    res.last             = last_res;
  end

  // datapath: scan accumulation and entry updates
  always_comb begin
    valid_nxt     = valid_r;
    due_nxt       = due_r;
    tag_cnt_nxt   = tag_cnt_r;
    scan_cnt_nxt  = scan_cnt_r;
    any_nxt       = any_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    best_ival_nxt = best_ival_r;
    best_tag_nxt  = best_tag_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    first_nxt     = first_r;
    n_nxt         = n_r;
    emit_nxt      = emit_r;
    nv_nxt        = nv_r;
    nx_nxt        = nx_r;
    ent_we        = 1'b0;
    ent_waddr     = best_idx_r;
    ent_wdata     = '{tag: best_tag_r, interval: best_ival_r, expire: resched};
    rec_we        = 1'b0;
    rec_waddr     = n_r[AW-1:0];
    rec_wdata     = '{kind: KIND_NONE, slot: '0, tag: '0, ok: 1'b0,
                      earliest_changed: 1'b0};

    if (accept) begin
      n_nxt     = '0;
      first_nxt = 1'b1;
    end

    // advance the scan address
    if (state_r == ST_SCAN) scan_cnt_nxt = scan_cnt_r + AW'(1);

    // fold in the entry read in the previous cycle
    if (rd_vld_r) begin
      case (mode_r)
        SM_ADD: begin
          if (!valid_r[rd_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (valid_r[rd_idx_r] && (!any_r || ent_rdata.expire < best_r)) begin
            any_nxt  = 1'b1;
            best_nxt = ent_rdata.expire;
          end
        end
        SM_PICK: begin
          logic cand;
          if (first_r) begin
            cand = valid_r[rd_idx_r] && (ent_rdata.expire <= cmd_r.current_time);
            due_nxt[rd_idx_r] = cand;
          end else begin
            cand = due_r[rd_idx_r];
          end
          if (cand && (!any_r || ent_rdata.expire < best_r)) begin
            any_nxt       = 1'b1;
            best_nxt      = ent_rdata.expire;
            best_idx_nxt  = rd_idx_r;
            best_ival_nxt = ent_rdata.interval;
            best_tag_nxt  = ent_rdata.tag;
          end
        end
        default: begin
          if (valid_r[rd_idx_r] && (!any_r || ent_rdata.expire < best_r)) begin
            any_nxt  = 1'b1;
            best_nxt = ent_rdata.expire;
          end
        end
      endcase
    end

    // act on a finished scan
    if (state_r == ST_DECIDE) begin
      case (mode_r)
        SM_ADD: begin
          rec_we = 1'b1;
          n_nxt  = CW'(1);
          if (free_r) begin
            tag_cnt_nxt           = tag_cnt_r + TagW'(1);
            valid_nxt[free_idx_r] = 1'b1;
            ent_we                = 1'b1;
            ent_waddr             = free_idx_r;
            ent_wdata             = '{tag: tag_cnt_r + TagW'(1),
                                      interval: cmd_r.repeat_interval,
                                      expire: cmd_r.expire_time};
            rec_wdata = '{kind: KIND_ADD, slot: SlotW'(free_idx_r),
                          tag: tag_cnt_r + TagW'(1), ok: 1'b1,
                          earliest_changed: !any_r || (cmd_r.expire_time < best_r)};
          end else begin
            rec_wdata = '{kind: KIND_ADD, slot: '0, tag: '0, ok: 1'b0,
                          earliest_changed: 1'b0};
          end
        end
        SM_PICK: begin
          first_nxt = 1'b0;
          if (any_r) begin
            due_nxt[best_idx_r]   = 1'b0;
            valid_nxt[best_idx_r] = (best_ival_r != '0);
            ent_we    = (best_ival_r != '0);
            rec_we    = 1'b1;
            rec_wdata = '{kind: KIND_EXPIRED, slot: SlotW'(best_idx_r),
                          tag: best_tag_r, ok: 1'b1, earliest_changed: 1'b0};
            n_nxt     = n_r + CW'(1);
          end else if (n_r == '0) begin
            rec_we = 1'b1;
            n_nxt  = CW'(1);
          end
        end
        default: begin
          nv_nxt   = any_r;
          nx_nxt   = any_r ? best_r : '0;
          emit_nxt = '0;
        end
      endcase
    end

    // cancel: check the handle read at the target slot
    if (state_r == ST_CDEC) begin
      logic found;
      found = cslot_ok && valid_r[cslot] && (ent_rdata.tag == cmd_r.target_tag);
      if (found) valid_nxt[cslot] = 1'b0;
      rec_we    = 1'b1;
      rec_wdata = '{kind: KIND_CANCEL, slot: cmd_r.target_slot,
                    tag: cmd_r.target_tag, ok: found, earliest_changed: 1'b0};
      n_nxt     = CW'(1);
    end

    // unused op: one empty result
    if (state_r == ST_OTHER) begin
      rec_we = 1'b1;
      n_nxt  = CW'(1);
    end

    // step the emission index
    if (state_r == ST_EOUT && res_ready && !last_res) emit_nxt = emit_r + CW'(1);

    // clear accumulators at the start of every scan
    if (start_scan) begin
      scan_cnt_nxt = '0;
      any_nxt      = 1'b0;
      free_nxt     = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= SM_NEXT;
      valid_r   <= '0;
      tag_cnt_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      valid_r   <= valid_nxt;
      tag_cnt_r <= tag_cnt_nxt;
      rd_vld_r  <= (state_r == ST_SCAN);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) cmd_r <= cmd;
    rd_idx_r    <= scan_cnt_r;
    due_r       <= due_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    any_r       <= any_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    best_ival_r <= best_ival_nxt;
    best_tag_r  <= best_tag_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    first_r     <= first_nxt;
    n_r         <= n_nxt;
    emit_r      <= emit_nxt;
    nv_r        <= nv_nxt;
    nx_r        <= nx_nxt;
  end

endmodule

// File: hdl/timer_expiry_queue_unit.sv
// Top level of the timer expiry queue: entry RAM, result RAM, sequencer and
// output register. Depends on teq_pkg, teq_ram and teq_ctrl.
//
//  channel | direction | tdata                          | tuser | tlast
//  in_     | slave     | expire_time, repeat_interval,  | op    | -
//          |           | target_slot, target_tag,       |       |
//          |           | current_time                   |       |
//  out_    | master    | slot, tag, ok, earliest_chg,   | kind  | last
//          |           | next_valid, next_expire        |       |
//
// Each table scan reads the entry RAM once per slot.
// Add takes one scan plus the final earliest scan.
// Cancel takes a read and a check plus the final scan.
// Expire takes one scan per expired timer plus two.
// Each result then leaves through the result RAM in a read state and an output state.
// Reset is synchronous, active low; all slots read empty after it, no sweep.
// in_tready stays low until the last result of the word has been taken.
module timer_expiry_queue_unit import teq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // expire_time[47:0], repeat_interval[95:48], target_slot[99:96],
  // target_tag[131:100], current_time[179:132], zero pad
  input  logic [183:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // slot[3:0], tag[35:4], ok[36], earliest_changed[37], next_valid[38],
  // next_expire[86:39], zero pad
  output logic [87:0]  out_tdata,
  // kind[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  localparam int AW = $clog2(CAPACITY);

  cmd_t          cmd;
  logic          ent_we;
  logic [AW-1:0] ent_waddr, ent_raddr;
  entry_t        ent_wdata, ent_rdata;
  logic          rec_we;
  logic [AW-1:0] rec_waddr, rec_raddr;
  rec_t          rec_wdata, rec_rdata;
  logic          res_valid, res_ready;
  res_t          res;
  logic          out_valid_r;
  res_t          out_r;

  // unpack the input word
  assign cmd.op              = in_tuser;
  assign cmd.expire_time     = in_tdata[47:0];
  assign cmd.repeat_interval = in_tdata[95:48];
  assign cmd.target_slot     = in_tdata[99:96];
  assign cmd.target_tag      = in_tdata[131:100];
  assign cmd.current_time    = in_tdata[179:132];

  teq_ram #(.W($bits(entry_t)), .D(CAPACITY)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  teq_ram #(.W($bits(rec_t)), .D(CAPACITY)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  teq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .ent_raddr (ent_raddr),
    .ent_rdata (ent_rdata),
    .rec_we    (rec_we),
    .rec_waddr (rec_waddr),
    .rec_wdata (rec_wdata),
    .rec_raddr (rec_raddr),
    .rec_rdata (rec_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {1'b0, out_r.next_expire, out_r.next_valid,
                       out_r.earliest_changed, out_r.ok, out_r.tag, out_r.slot};

endmodule

// File: hdl/teq_checker.sv
// Port-level checks of the timer expiry queue result stream, with bind.
// Depends on teq_pkg and timer_expiry_queue_unit.
module teq_checker import teq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // add, cancel and empty replies are single words
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ADD || out_tuser == KIND_CANCEL ||
                   out_tuser == KIND_NONE) |-> out_tlast)
    else $error("single reply without last");

  // expired timers always report ok and no earliest change
  a_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_EXPIRED |-> out_tdata[36] && !out_tdata[37])
    else $error("expired word with bad flags");

  // a refused add carries no handle
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ADD && !out_tdata[36]
    |-> out_tdata[35:0] == '0 && !out_tdata[37])
    else $error("refused add carries a handle");

  // nothing pending means a zero next expiry
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[38] |-> out_tdata[86:39] == '0)
    else $error("next expiry set with nothing pending");

endmodule

bind timer_expiry_queue_unit teq_checker u_teq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/sv/timer_expiry_queue_unit_test.sv
// Testbench for timer_expiry_queue_unit: drives add, cancel, expire and unused-op words and
// checks every result word against a behavioural timer table kept in a scoreboard.
// Depends on teq_pkg and the timer_expiry_queue_unit RTL.
module timer_expiry_queue_unit_test;
  import teq_pkg::*;

  localparam int Slots = 16;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic        ok;
    logic        ec;
    logic        nv;
    logic [47:0] nx;
    logic        last;
  } reply_t;

  // Timer table model and queue of pending replies
  class timer_table_sb;
    bit          live[Slots];
    logic [47:0] due_at[Slots];
    logic [47:0] period[Slots];
    logic [31:0] tags[Slots];
    logic [31:0] tag_count;
    reply_t      pending[$];
    int          errors;

    function void clear();
      foreach (live[i]) live[i] = 0;
      tag_count = 0;
      pending.delete();
      errors = 0;
    endfunction

    function bit soonest(output logic [47:0] t);
      bit any;
      any = 0;
      t = '0;
      for (int i = 0; i < Slots; i++)
        if (live[i] && (!any || due_at[i] < t)) begin
          t = due_at[i];
          any = 1;
        end
      return any;
    endfunction

    // Work out the replies caused by one accepted command word
    function void note_command(op_t op, logic [47:0] when, logic [47:0] ival,
                               logic [3:0] tslot, logic [31:0] ttag,
                               logic [47:0] now);
      reply_t r[$];
      reply_t one;
      int free_slot, pick, n0;
      bit any, nv;
      bit due[Slots];
      logic [47:0] cur, nx;
      logic [48:0] sum;
      one = '{KIND_NONE, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0};
      case (op)
        OP_ADD: begin
          free_slot = -1;
          for (int i = Slots - 1; i >= 0; i--) if (!live[i]) free_slot = i;
          one.kind = KIND_ADD;
          if (free_slot >= 0) begin
            any = soonest(cur);
            tag_count = tag_count + 1;
            live[free_slot] = 1;
            due_at[free_slot] = when;
            period[free_slot] = ival;
            tags[free_slot] = tag_count;
            one.slot = free_slot[3:0];
            one.tag = tag_count;
            one.ok = 1;
            one.ec = !any || when < cur;
          end
          r.push_back(one);
        end
        OP_CANCEL: begin
          one.kind = KIND_CANCEL;
          one.slot = tslot;
          one.tag = ttag;
          if (live[tslot] && tags[tslot] == ttag) begin
            live[tslot] = 0;
            one.ok = 1;
          end
          r.push_back(one);
        end
        OP_EXPIRE: begin
          for (int i = 0; i < Slots; i++) due[i] = live[i] && due_at[i] <= now;
          forever begin
            pick = -1;
            for (int i = 0; i < Slots; i++)
              if (due[i] && (pick < 0 || due_at[i] < due_at[pick])) pick = i;
            if (pick < 0) break;
            due[pick] = 0;
            live[pick] = 0;
            one.kind = KIND_EXPIRED;
            one.slot = pick[3:0];
            one.tag = tags[pick];
            one.ok = 1;
            r.push_back(one);
            if (period[pick] != 0) begin
              sum = {1'b0, now} + {1'b0, period[pick]};
              due_at[pick] = sum[48] ? TimeMax : sum[47:0];
              live[pick] = 1;
            end
          end
          if (r.size() == 0) r.push_back(one);
        end
        default: r.push_back(one);
      endcase
      nv = soonest(nx);
      n0 = r.size();
      for (int k = 0; k < n0; k++) begin
        r[k].nv = nv;
        r[k].nx = nv ? nx : 48'd0;
        r[k].last = (k == n0 - 1);
        pending.push_back(r[k]);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word kind=%0d", got.kind);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp k%0d s%0d t%h ok%b ec%b nv%b nx%h l%b / got k%0d s%0d t%h ok%b ec%b nv%b nx%h l%b",
                   want.kind, want.slot, want.tag, want.ok, want.ec, want.nv, want.nx,
                   want.last, got.kind, got.slot, got.tag, got.ok, got.ec, got.nv,
                   got.nx, got.last);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [183:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [87:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  timer_table_sb sb;
  int  cycles;
  bit  hold_off;
  int  stall_mode;
  logic [31:0] issued_tags[$];

  timer_expiry_queue_unit i_dut (.*);

  always #1 clk = ~clk;

  // Receiver: sample on the rising edge, change tready on the falling edge
  always @(posedge clk) begin
    reply_t got;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = kind_t'(out_tuser);
      got.slot = out_tdata[3:0];
      got.tag = out_tdata[35:4];
      got.ok = out_tdata[36];
      got.ec = out_tdata[37];
      got.nv = out_tdata[38];
      got.nx = out_tdata[86:39];
      got.last = out_tlast;
      sb.check_reply(got);
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_tready <= 0;
    else case (stall_mode)
      0: out_tready <= 1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= (cycles % 7 < 3);
    endcase
  end

  // Long receiver hold-off, counted in cycles
  task automatic stall_receiver(int n);
    hold_off = 1;
    repeat (n) @(posedge clk);
    hold_off = 0;
  endtask

  // Offer one command word and wait for its acceptance
  task automatic send_word(op_t op, logic [47:0] when, logic [47:0] ival,
                           logic [3:0] tslot, logic [31:0] ttag, logic [47:0] now);
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {4'd0, now, ttag, tslot, ival, when};
    do @(posedge clk); while (!in_tready);
    sb.note_command(op, when, ival, tslot, ttag, now);
    if (op == OP_ADD && sb.pending[$].ok) issued_tags.push_back(sb.pending[$].tag);
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    in_tvalid <= 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [47:0] rnd48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // One random word, mostly well-formed timer traffic with local times
  task automatic random_word(ref logic [47:0] clock_now);
    int sel;
    logic [31:0] t;
    logic [3:0]  s;
    sel = $urandom_range(0, 99);
    if (sel < 45)
      send_word(OP_ADD, ($urandom_range(0, 9) == 0) ? rnd48() :
                clock_now + 48'($urandom_range(0, 60)),
                ($urandom_range(0, 2) == 0) ? 48'd0 :
                (($urandom_range(0, 9) == 0) ? rnd48() : 48'($urandom_range(1, 40))),
                4'($urandom), $urandom, rnd48());
    else if (sel < 65) begin
      s = 4'($urandom);
      t = (issued_tags.size() != 0 && $urandom_range(0, 2) != 0) ?
          issued_tags[$urandom_range(0, issued_tags.size() - 1)] : $urandom;
      send_word(OP_CANCEL, rnd48(), rnd48(), s, t, rnd48());
    end else if (sel < 97) begin
      clock_now = clock_now + 48'($urandom_range(0, 30));
      send_word(OP_EXPIRE, rnd48(), rnd48(), 4'($urandom), $urandom,
                ($urandom_range(0, 19) == 0) ? rnd48() : clock_now);
    end else
      send_word(OP_UNUSED, rnd48(), rnd48(), 4'($urandom), $urandom, rnd48());
  endtask

  // Stop the run on timeout
  always @(posedge clk)
    if (cycles > CycleLimit) begin
      $display("timer_expiry_queue_unit_test: done, errors");
      $finish;
    end

  initial begin
    logic [47:0] clock_now;
    sb = new();
    sb.clear();
    cycles = 0;
    hold_off = 0;
    stall_mode = 0;
    clock_now = 48'd1000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: empty expire, unused op, cancel misses, fill to full, ties
    send_word(OP_EXPIRE, '0, '0, '0, '0, TimeMax);
    send_word(OP_UNUSED, TimeMax, TimeMax, 4'hF, 32'hFFFF_FFFF, TimeMax);
    send_word(OP_CANCEL, '0, '0, 4'd0, 32'd1, '0);
    send_word(OP_ADD, 48'd50, 48'd0, '0, '0, '0);
    send_word(OP_ADD, 48'd50, 48'd10, '0, '0, '0);
    send_word(OP_ADD, 48'd10, TimeMax, '0, '0, '0);
    send_word(OP_ADD, TimeMax, 48'd1, '0, '0, '0);
    send_word(OP_ADD, 48'd0, 48'd0, '0, '0, '0);
    send_word(OP_CANCEL, '0, '0, 4'd1, 32'd99, '0);
    send_word(OP_CANCEL, '0, '0, 4'd4, 32'd5, '0);
    for (int i = 0; i < 13; i++)
      send_word(OP_ADD, 48'd60 - i, 48'd0, '0, '0, '0);
    send_word(OP_EXPIRE, '0, '0, '0, '0, 48'd50);
    send_word(OP_EXPIRE, '0, '0, '0, '0, TimeMax);
    send_word(OP_EXPIRE, '0, '0, '0, '0, TimeMax);
    drain();

    // Long receiver hold-off while the sender keeps offering words
    stall_mode = 1;
    fork
      stall_receiver(400);
      for (int i = 0; i < 20; i++) random_word(clock_now);
    join
    drain();

    // Random bursts and gaps, changing the receiver pattern now and then
    for (int i = 0; i < 400; i++) begin
      if (i % 60 == 0) stall_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 12));
      random_word(clock_now);
      if (i == 200) drain();
    end
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("timer_expiry_queue_unit_test: done, clean");
    else
      $display("timer_expiry_queue_unit_test: done, errors");
    $finish;
  end
endmodule
